>>> rtl/core/assert_macros.svh
// Assertion macros for the top level of the window mean speller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, off while arst_n is low.
`define FWMS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Check that a condition never holds.
`define FWMS_ASSERT_NEVER(label, cond, msg) \
	`FWMS_ASSERT(label, !(cond), msg)

`endif

>>> rtl/core/fwms_pkg.sv
// Package: widths, register indexes, state type and pitch tables of the speller.
package fwms_pkg;

	localparam int WINDOW_DEPTH = 1024;
	localparam int PTR_W        = $clog2(WINDOW_DEPTH);
	localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

	localparam int CODE_W    = 6;
	localparam int TIME_W    = 32;
	localparam int FIFTH_W   = 6;
	localparam int MEAN_W    = 14;
	localparam int BIAS_W    = 2;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;

	localparam int CODE_SPAN   = 40;
	localparam int FIFTH_MAX   = 19;
	localparam int FRAC_W      = 8;
	localparam int SPREAD      = 6;
	localparam int BIAS_SCALE  = 3;
	localparam int BIAS_OFFSET = 10;

	localparam int SUM_W      = $clog2(FIFTH_MAX * WINDOW_DEPTH + 1) + 1;
	localparam int DVD_W      = SUM_W - 1 + FRAC_W;
	localparam int DIV_STEP_W = $clog2(DVD_W + 1);
	localparam int P_W        = 2 * CNT_W + 1;
	localparam int CMP_W      = 2 * CNT_W + 8;
	localparam int ENTRY_W    = FIFTH_W + TIME_W;

	localparam logic [TIME_W-1:0] WINDOW_TICKS_RST = TIME_W'(1920);

	typedef logic signed [FIFTH_W-1:0] fifth_t;

	localparam fifth_t NO_FLAT_MIDDLE = -FIFTH_W'(4);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_TICKS  = 2'd0,
		REG_SPELLING_MODE = 2'd1,
		REG_START_BIAS    = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_TERM,
		ST_CMP,
		ST_OVF_RD,
		ST_OVF_DROP,
		ST_WRITE,
		ST_EV_RD,
		ST_EV_CHK,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_OUT
	} fwms_state_t;

	function automatic logic code_unused(input logic [CODE_W-1:0] code);
		logic r;
		case (code)
			6'd5, 6'd11, 6'd22, 6'd28, 6'd34: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic fifth_t lof_of_code(input logic [CODE_W-1:0] code);
		fifth_t r;
		case (code)
			6'd0:  r = -6'sd14;
			6'd1:  r = -6'sd7;
			6'd2:  r = 6'sd0;
			6'd3:  r = 6'sd7;
			6'd4:  r = 6'sd14;
			6'd6:  r = -6'sd12;
			6'd7:  r = -6'sd5;
			6'd8:  r = 6'sd2;
			6'd9:  r = 6'sd9;
			6'd10: r = 6'sd16;
			6'd12: r = -6'sd10;
			6'd13: r = -6'sd3;
			6'd14: r = 6'sd4;
			6'd15: r = 6'sd11;
			6'd16: r = 6'sd18;
			6'd17: r = -6'sd15;
			6'd18: r = -6'sd8;
			6'd19: r = -6'sd1;
			6'd20: r = 6'sd6;
			6'd21: r = 6'sd13;
			6'd23: r = -6'sd13;
			6'd24: r = -6'sd6;
			6'd25: r = 6'sd1;
			6'd26: r = 6'sd8;
			6'd27: r = 6'sd15;
			6'd29: r = -6'sd11;
			6'd30: r = -6'sd4;
			6'd31: r = 6'sd3;
			6'd32: r = 6'sd10;
			6'd33: r = 6'sd17;
			6'd35: r = -6'sd9;
			6'd36: r = -6'sd2;
			6'd37: r = 6'sd5;
			6'd38: r = 6'sd12;
			6'd39: r = 6'sd19;
			default: r = 6'sd0;
		endcase
		return r;
	endfunction

	// Middle enharmonic candidate of the note's twelve-tone class.
	function automatic fifth_t middle_of_code(input logic [CODE_W-1:0] code);
		fifth_t r;
		case (code)
			6'd0, 6'd32, 6'd36:          r = -6'sd2;
			6'd1, 6'd33, 6'd37:          r = 6'sd5;
			6'd2, 6'd6, 6'd38:           r = 6'sd0;
			6'd3, 6'd7, 6'd39:           r = 6'sd7;
			6'd4, 6'd8, 6'd12:           r = 6'sd2;
			6'd9, 6'd13, 6'd17:          r = -6'sd3;
			6'd10, 6'd14, 6'd18:         r = 6'sd4;
			6'd15, 6'd19, 6'd23:         r = -6'sd1;
			6'd16, 6'd20, 6'd24:         r = 6'sd6;
			6'd21, 6'd25, 6'd29:         r = 6'sd1;
			6'd26, 6'd30:                r = -6'sd4;
			6'd27, 6'd31, 6'd35:         r = 6'sd3;
			default:                     r = 6'sd0;
		endcase
		return r;
	endfunction

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(WINDOW_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

endpackage

>>> rtl/core/fwms_if.sv
// Interfaces: note input channel and result output channel.
interface fwms_note_if;
	import fwms_pkg::*;

	logic                valid;
	logic                ready;
	logic [CODE_W-1:0]   pitch_code;
	logic [TIME_W-1:0]   note_time;

	modport source (output valid, output pitch_code, output note_time, input ready);
	modport sink (input valid, input pitch_code, input note_time, output ready);
endinterface

interface fwms_result_if;
	import fwms_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [FIFTH_W-1:0] fifth_value;
	logic signed [MEAN_W-1:0]  window_mean;
	logic [CNT_W-1:0]          window_count;
	logic                      was_respelled;
	logic                      window_overflow;

	modport source (output valid, output fifth_value, output window_mean,
		output window_count, output was_respelled, output window_overflow, input ready);
	modport sink (input valid, input fifth_value, input window_mean,
		input window_count, input was_respelled, input window_overflow, output ready);
endinterface

>>> rtl/core/fifths_window_mean_speller.sv
// Top level: line-of-fifths speller with a sliding-window mean over a RAM FIFO.
//
//   channel      dir   handshake       payload
//   note_in      in    valid/ready     pitch_code, note_time
//   result_out   out   valid/ready     fifth_value, window_mean, window_count,
//                                      was_respelled, window_overflow
//   cfg          in    cfg_we          cfg_index, cfg_data
//
// Respelling, a full FIFO and each evicted note add states to a note's work;
// the 23-step mean divider and the single read port of the FIFO RAM (one
// eviction check per read) set its pace.
// Unused pitch codes finish in the decode state with no result.
// Reset clears control state only; RAM entries are read only after being written.
// note_in.ready is high only between notes; a waiting result does not block
// acceptance, but the next result holds until the output register frees.
`include "assert_macros.svh"

module fifths_window_mean_speller (
	input  logic                           clk,
	input  logic                           arst_n,
	fwms_note_if.sink                      note_in,
	fwms_result_if.source                  result_out,
	input  logic                           cfg_we,
	input  logic [fwms_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fwms_pkg::CFG_W-1:0]     cfg_data
);
	import fwms_pkg::*;

	fwms_state_t state_q, state_d;

	logic [TIME_W-1:0]       window_q;
	logic                    mode_q;
	logic signed [BIAS_W-1:0] bias_q;

	logic [CNT_W-1:0]        count_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [PTR_W-1:0]        head_q;
	logic [PTR_W-1:0]        tail_q;

	logic [CODE_W-1:0]       code_q;
	logic [TIME_W-1:0]       time_q;
	fifth_t                  given_q;
	fifth_t                  y_q;
	fifth_t                  chosen_q;
	logic                    biased_q;
	logic                    ovf_q;
	logic [P_W-1:0]          p_q;
	logic [P_W-1:0]          d_q;
	logic signed [CMP_W-1:0] l_q;

	logic                    out_valid_q;
	fifth_t                  out_fifth_q;
	logic signed [MEAN_W-1:0] out_mean_q;
	logic [CNT_W-1:0]        out_count_q;
	logic                    out_resp_q;
	logic                    out_ovf_q;

	logic                    note_accept;
	logic                    load_out;
	logic                    ram_we;
	logic                    div_start;
	logic                    div_done;
	logic [DVD_W-1:0]        div_quo;
	logic [ENTRY_W-1:0]      ram_rdata;

	logic [CODE_W-1:0]       code_r;
	logic                    code_bad;
	logic [CNT_W:0]          m_w;
	logic signed [3:0]       b3;
	logic signed [P_W:0]     pn;
	fifth_t                  t_hi;
	fifth_t                  t_lo;
	logic signed [CMP_W-1:0] prod_hi;
	logic signed [CMP_W-1:0] prod_lo;
	fifth_t                  pick;
	fifth_t                  rd_fifth;
	logic [TIME_W-1:0]       rd_time;
	logic                    evict;
	logic                    sum_neg;
	logic [SUM_W-1:0]        sum_mag;
	logic [DVD_W-1:0]        dividend;
	logic [MEAN_W-1:0]       quo_n;

	// Decode and respelling arithmetic
	assign code_r   = (code_q >= CODE_W'(CODE_SPAN)) ? code_q - CODE_W'(CODE_SPAN) : code_q;
	assign code_bad = code_unused(code_r);
	assign m_w      = {1'b0, count_q} + (CNT_W + 1)'(BIAS_OFFSET);
	assign b3       = 4'(BIAS_SCALE) * {{2{bias_q[BIAS_W-1]}}, bias_q};
	assign pn       = $signed({1'b0, p_q - P_W'(count_q)});
	assign t_hi     = y_q + FIFTH_W'(SPREAD);
	assign t_lo     = y_q - FIFTH_W'(SPREAD);
	assign prod_hi  = CMP_W'(t_hi) * CMP_W'($signed({1'b0, d_q}));
	assign prod_lo  = CMP_W'(t_lo) * CMP_W'($signed({1'b0, d_q}));

	always_comb begin
		if (l_q > prod_hi) begin
			pick = y_q + FIFTH_W'(2 * SPREAD);
		end else if (y_q == NO_FLAT_MIDDLE || l_q > prod_lo) begin
			pick = y_q;
		end else begin
			pick = y_q - FIFTH_W'(2 * SPREAD);
		end
	end

	// FIFO entry read at the tail
	assign rd_fifth = fifth_t'(ram_rdata[ENTRY_W-1:TIME_W]);
	assign rd_time  = ram_rdata[TIME_W-1:0];
	assign evict    = (count_q != '0) && (time_q >= rd_time) &&
		((time_q - rd_time) > window_q);

	// Mean = sum * 256 / count, truncated toward zero
	assign sum_neg  = sum_q[SUM_W-1];
	assign sum_mag  = sum_neg ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign dividend = {sum_mag[SUM_W-2:0], FRAC_W'(0)};
	assign quo_n    = MEAN_W'(div_quo);

	assign note_accept = note_in.valid && note_in.ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (note_in.valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (code_bad) begin
					state_d = ST_IDLE;
				end else if (mode_q) begin
					state_d = ST_TERM;
				end else begin
					state_d = ST_OVF_RD;
				end
			end
			ST_TERM:      state_d = ST_CMP;
			ST_CMP:       state_d = ST_OVF_RD;
			ST_OVF_RD: begin
				if (count_q == CNT_W'(WINDOW_DEPTH)) begin
					state_d = ST_OVF_DROP;
				end else begin
					state_d = ST_WRITE;
				end
			end
			ST_OVF_DROP:  state_d = ST_WRITE;
			ST_WRITE:     state_d = ST_EV_RD;
			ST_EV_RD:     state_d = ST_EV_CHK;
			ST_EV_CHK: begin
				if (evict) begin
					state_d = ST_EV_RD;
				end else begin
					state_d = ST_DIV_START;
				end
			end
			ST_DIV_START: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		note_in.ready = 1'b0;
		ram_we        = 1'b0;
		div_start     = 1'b0;
		load_out      = 1'b0;
		case (state_q)
			ST_IDLE:      note_in.ready = 1'b1;
			ST_WRITE:     ram_we = 1'b1;
			ST_DIV_START: div_start = 1'b1;
			ST_OUT:       load_out = !out_valid_q || result_out.ready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_TICKS_RST;
			mode_q   <= 1'b0;
			bias_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_WINDOW_TICKS:  window_q <= cfg_data[TIME_W-1:0];
				REG_SPELLING_MODE: mode_q <= cfg_data[0];
				REG_START_BIAS:    bias_q <= cfg_data[BIAS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Window bookkeeping: count, sum and FIFO pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_DECODE:   ovf_q <= 1'b0;
				ST_OVF_DROP: begin
					sum_q   <= sum_q - SUM_W'(rd_fifth);
					tail_q  <= ptr_next(tail_q);
					count_q <= count_q - CNT_W'(1);
					ovf_q   <= 1'b1;
				end
				ST_WRITE: begin
					sum_q   <= sum_q + SUM_W'(chosen_q);
					head_q  <= ptr_next(head_q);
					count_q <= count_q + CNT_W'(1);
				end
				ST_EV_CHK: begin
					if (evict) begin
						sum_q   <= sum_q - SUM_W'(rd_fifth);
						tail_q  <= ptr_next(tail_q);
						count_q <= count_q - CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Per-note working registers
	always_ff @(posedge clk) begin
		if (note_accept) begin
			code_q <= note_in.pitch_code;
			time_q <= note_in.note_time;
		end
		case (state_q)
			ST_DECODE: begin
				given_q  <= lof_of_code(code_r);
				chosen_q <= lof_of_code(code_r);
				y_q      <= middle_of_code(code_r);
				biased_q <= time_q <= window_q;
				p_q      <= P_W'(count_q) * P_W'(m_w);
			end
			ST_TERM: begin
				if (!biased_q) begin
					if (count_q == '0) begin
						l_q <= '0;
						d_q <= P_W'(1);
					end else begin
						l_q <= CMP_W'(sum_q);
						d_q <= P_W'(count_q);
					end
				end else if (count_q == '0) begin
					l_q <= CMP_W'(b3) * CMP_W'(BIAS_OFFSET - 1);
					d_q <= P_W'(BIAS_OFFSET);
				end else begin
					l_q <= CMP_W'(b3) * CMP_W'(pn) +
						CMP_W'(sum_q) * CMP_W'($signed(m_w));
					d_q <= p_q;
				end
			end
			ST_CMP: chosen_q <= pick;
			default: begin
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_fifth_q <= chosen_q;
			out_mean_q  <= sum_neg ? $signed(-quo_n) : $signed(quo_n);
			out_count_q <= count_q;
			out_resp_q  <= chosen_q != given_q;
			out_ovf_q   <= ovf_q;
		end
	end

	assign result_out.valid           = out_valid_q;
	assign result_out.fifth_value     = out_fifth_q;
	assign result_out.window_mean     = out_mean_q;
	assign result_out.window_count    = out_count_q;
	assign result_out.was_respelled   = out_resp_q;
	assign result_out.window_overflow = out_ovf_q;

	fwms_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (WINDOW_DEPTH)
	) u_fifo_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (head_q),
		.wdata ({chosen_q, time_q}),
		.raddr (tail_q),
		.rdata (ram_rdata)
	);

	fwms_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	`FWMS_ASSERT_NEVER(a_count_max, count_q > CNT_W'(WINDOW_DEPTH), "window count above depth")
	`FWMS_ASSERT(a_div_nonzero, state_q == ST_DIV_START |-> count_q != '0, "mean of empty window")
	`FWMS_ASSERT(a_out_load, $rose(out_valid_q) |-> $past(state_q) == ST_OUT, "result out of order")
endmodule

>>> rtl/core/fwms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module fwms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

>>> rtl/core/fwms_div.sv
// Restoring divider: one quotient bit per cycle for the Q8 window mean.
module fwms_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [fwms_pkg::DVD_W-1:0] dividend,
	input  logic [fwms_pkg::CNT_W-1:0] divisor,
	output logic                       done,
	output logic [fwms_pkg::DVD_W-1:0] quotient
);
	import fwms_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [DIV_STEP_W-1:0] step_q;
	logic [CNT_W-1:0]      rem_q;
	logic [CNT_W-1:0]      dvs_q;
	logic [DVD_W-1:0]      work_q;

	logic [CNT_W:0]        trial;
	logic [CNT_W:0]        diff;
	logic                  fits;

	assign trial = {rem_q, work_q[DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= DIV_STEP_W'(DVD_W);
			end else if (busy_q) begin
				step_q <= step_q - DIV_STEP_W'(1);
				if (step_q == DIV_STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			dvs_q  <= divisor;
			work_q <= dividend;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			work_q <= {work_q[DVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = work_q;
endmodule
